/* rtl/obbpot_pkg.sv */
`default_nettype none

package obbpot_pkg;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 256;
  localparam int unsigned OUT_TDATA_W = 8;

  // One oriented box: center Q15.8, half extents Q15.8, first axis Q1.14
  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic        [22:0] hx;
    logic        [22:0] hy;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
  } box_t;

  // After stage 1: center offset and the axis-by-axis products
  typedef struct packed {
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic        [22:0] ahx;
    logic        [22:0] ahy;
    logic        [22:0] bhx;
    logic        [22:0] bhy;
    logic signed [15:0] a_cs;
    logic signed [15:0] a_sn;
    logic signed [15:0] b_cs;
    logic signed [15:0] b_sn;
    logic signed [31:0] aa_cc;   // a_cs * a_cs
    logic signed [31:0] aa_ss;   // a_sn * a_sn
    logic signed [31:0] bb_cc;   // b_cs * b_cs
    logic signed [31:0] bb_ss;   // b_sn * b_sn
    logic signed [31:0] ab_cc;   // a_cs * b_cs
    logic signed [31:0] ab_ss;   // a_sn * b_sn
    logic signed [31:0] ab_cs;   // a_cs * b_sn
    logic signed [31:0] ab_sc;   // a_sn * b_cs
  } s1_t;

  // After stage 2: axis norms, |cross dots| and offset projection products
  typedef struct packed {
    logic        [22:0] ahx;
    logic        [22:0] ahy;
    logic        [22:0] bhx;
    logic        [22:0] bhy;
    logic        [31:0] na;      // |A0|^2 = A0.A0 = A1.A1
    logic        [31:0] nb;      // |B0|^2
    logic        [31:0] p_abs;   // |A0.B0| = |A1.B1|
    logic        [31:0] q_abs;   // |A0.B1| = |A1.B0|
    logic signed [40:0] dx_ac;
    logic signed [40:0] dy_as;
    logic signed [40:0] dy_ac;
    logic signed [40:0] dx_as;
    logic signed [40:0] dx_bc;
    logic signed [40:0] dy_bs;
    logic signed [40:0] dy_bc;
    logic signed [40:0] dx_bs;
  } s2_t;

  // After stage 3: |d.u| per axis and the radius partial products
  typedef struct packed {
    logic [3:0][40:0] dproj;
    logic [54:0] ahx_na;
    logic [54:0] ahy_na;
    logic [54:0] bhx_nb;
    logic [54:0] bhy_nb;
    logic [54:0] ahx_p;
    logic [54:0] ahx_q;
    logic [54:0] ahy_p;
    logic [54:0] ahy_q;
    logic [54:0] bhx_p;
    logic [54:0] bhx_q;
    logic [54:0] bhy_p;
    logic [54:0] bhy_q;
  } s3_t;

  // After stage 4: per-axis distance and radius sum
  typedef struct packed {
    logic [3:0][40:0] dproj;
    logic [3:0][55:0] rsum;
  } s4_t;

endpackage

`default_nettype wire

/* rtl/obb_pair_overlap_test.sv */
`default_nettype none

// Channel  Dir  tdata fields (low bit first)
// in_      in   a_cx[23:0] a_cy[47:24] a_hx[70:48] a_hy[93:71] a_cos[109:94]
//               a_sin[125:110] b_cx[149:126] b_cy[173:150] b_hx[196:174]
//               b_hy[219:197] b_cos[235:220] b_sin[251:236], zero pad [255:252]
// out_     out  overlap[0], zero pad [7:1]
//
// Five register stages; one box pair enters per cycle unless back pressure
// stalls the pipe. The stage 3 radius multipliers (23 x 32) set the depth.
// Each stage holds while its successor is full and stalled; empty stages
// keep filling, so bubbles close up under back pressure.
// Reset clears the stage valid bits only.
module obb_pair_overlap_test (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // box A cx, cy, hx, hy, cos, sin, then box B the same, from bit 0
  input  wire logic [obbpot_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // overlap in bit 0, zeros above
  output logic [obbpot_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  obbpot_pkg::box_t box_a;
  obbpot_pkg::box_t box_b;
  obbpot_pkg::s2_t  s2_data;
  obbpot_pkg::s4_t  s4_data;
  logic             s2_valid;
  logic             s2_ready;
  logic             s4_valid;
  logic             s4_ready;
  logic             overlap;

  // Unpack the input transaction
  assign box_a.cx = in_tdata[23:0];
  assign box_a.cy = in_tdata[47:24];
  assign box_a.hx = in_tdata[70:48];
  assign box_a.hy = in_tdata[93:71];
  assign box_a.cs = in_tdata[109:94];
  assign box_a.sn = in_tdata[125:110];
  assign box_b.cx = in_tdata[149:126];
  assign box_b.cy = in_tdata[173:150];
  assign box_b.hx = in_tdata[196:174];
  assign box_b.hy = in_tdata[219:197];
  assign box_b.cs = in_tdata[235:220];
  assign box_b.sn = in_tdata[251:236];

  obbpot_cross u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .box_a    (box_a),
    .box_b    (box_b),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  obbpot_proj u_proj (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (s4_valid),
    .dn_ready (s4_ready),
    .dn_data  (s4_data)
  );

  obbpot_cmp u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s4_valid),
    .up_ready (s4_ready),
    .up_data  (s4_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .overlap  (overlap)
  );

  // Pack the result transaction
  assign out_tdata = {{(obbpot_pkg::OUT_TDATA_W-1){1'b0}}, overlap};

endmodule

`default_nettype wire

/* rtl/obbpot_cross.sv */
`default_nettype none

// Stages 1 and 2: center offset, axis products, norms, cross dots and
// offset projection products.
module obbpot_cross (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire obbpot_pkg::box_t   box_a,
  input  wire obbpot_pkg::box_t   box_b,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output obbpot_pkg::s2_t         dn_data
);

  logic            s1_valid_r;
  logic            s2_valid_r;
  logic            s1_en;
  logic            s2_en;
  obbpot_pkg::s1_t s1_r;
  obbpot_pkg::s1_t s1_nxt;
  obbpot_pkg::s2_t s2_r;
  obbpot_pkg::s2_t s2_nxt;
  logic [32:0]     p_sum;
  logic [32:0]     q_sum;

  // Each stage advances when empty or when the next one advances
  assign s2_en    = !s2_valid_r || dn_ready;
  assign s1_en    = !s1_valid_r || s2_en;
  assign up_ready = s1_en;
  assign dn_valid = s2_valid_r;
  assign dn_data  = s2_r;

  // Stage 1: offset and the eight 16x16 axis products
  always_comb begin
    s1_nxt.dx    = {box_b.cx[23], box_b.cx} - {box_a.cx[23], box_a.cx};
    s1_nxt.dy    = {box_b.cy[23], box_b.cy} - {box_a.cy[23], box_a.cy};
    s1_nxt.ahx   = box_a.hx;
    s1_nxt.ahy   = box_a.hy;
    s1_nxt.bhx   = box_b.hx;
    s1_nxt.bhy   = box_b.hy;
    s1_nxt.a_cs  = box_a.cs;
    s1_nxt.a_sn  = box_a.sn;
    s1_nxt.b_cs  = box_b.cs;
    s1_nxt.b_sn  = box_b.sn;
    s1_nxt.aa_cc = 32'($signed(box_a.cs)) * 32'($signed(box_a.cs));
    s1_nxt.aa_ss = 32'($signed(box_a.sn)) * 32'($signed(box_a.sn));
    s1_nxt.bb_cc = 32'($signed(box_b.cs)) * 32'($signed(box_b.cs));
    s1_nxt.bb_ss = 32'($signed(box_b.sn)) * 32'($signed(box_b.sn));
    s1_nxt.ab_cc = 32'($signed(box_a.cs)) * 32'($signed(box_b.cs));
    s1_nxt.ab_ss = 32'($signed(box_a.sn)) * 32'($signed(box_b.sn));
    s1_nxt.ab_cs = 32'($signed(box_a.cs)) * 32'($signed(box_b.sn));
    s1_nxt.ab_sc = 32'($signed(box_a.sn)) * 32'($signed(box_b.cs));
  end

  // Stage 2: norms, absolute cross dots, offset times axis components
  always_comb begin
    p_sum = {s1_r.ab_cc[31], s1_r.ab_cc} + {s1_r.ab_ss[31], s1_r.ab_ss};
    q_sum = {s1_r.ab_sc[31], s1_r.ab_sc} - {s1_r.ab_cs[31], s1_r.ab_cs};

    s2_nxt.ahx   = s1_r.ahx;
    s2_nxt.ahy   = s1_r.ahy;
    s2_nxt.bhx   = s1_r.bhx;
    s2_nxt.bhy   = s1_r.bhy;
    // squares are never negative, so the sums fit 32 unsigned bits
    s2_nxt.na    = 32'(s1_r.aa_cc) + 32'(s1_r.aa_ss);
    s2_nxt.nb    = 32'(s1_r.bb_cc) + 32'(s1_r.bb_ss);
    s2_nxt.p_abs = p_sum[32] ? 32'(~p_sum + 33'd1) : p_sum[31:0];
    s2_nxt.q_abs = q_sum[32] ? 32'(~q_sum + 33'd1) : q_sum[31:0];
    s2_nxt.dx_ac = 41'($signed(s1_r.dx)) * 41'($signed(s1_r.a_cs));
    s2_nxt.dy_as = 41'($signed(s1_r.dy)) * 41'($signed(s1_r.a_sn));
    s2_nxt.dy_ac = 41'($signed(s1_r.dy)) * 41'($signed(s1_r.a_cs));
    s2_nxt.dx_as = 41'($signed(s1_r.dx)) * 41'($signed(s1_r.a_sn));
    s2_nxt.dx_bc = 41'($signed(s1_r.dx)) * 41'($signed(s1_r.b_cs));
    s2_nxt.dy_bs = 41'($signed(s1_r.dy)) * 41'($signed(s1_r.b_sn));
    s2_nxt.dy_bc = 41'($signed(s1_r.dy)) * 41'($signed(s1_r.b_cs));
    s2_nxt.dx_bs = 41'($signed(s1_r.dx)) * 41'($signed(s1_r.b_sn));
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_r <= up_valid;
      end
      if (s2_en) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_r <= s1_nxt;
    end
    if (s2_en) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/obbpot_proj.sv */
`default_nettype none

// Stages 3 and 4: absolute projected distances, radius products and
// per-axis radius sums.
module obbpot_proj (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire obbpot_pkg::s2_t    up_data,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output obbpot_pkg::s4_t         dn_data
);

  logic             s3_valid_r;
  logic             s4_valid_r;
  logic             s3_en;
  logic             s4_en;
  obbpot_pkg::s3_t  s3_r;
  obbpot_pkg::s3_t  s3_nxt;
  obbpot_pkg::s4_t  s4_r;
  obbpot_pkg::s4_t  s4_nxt;
  logic [3:0][41:0] dsum;

  assign s4_en    = !s4_valid_r || dn_ready;
  assign s3_en    = !s3_valid_r || s4_en;
  assign up_ready = s3_en;
  assign dn_valid = s4_valid_r;
  assign dn_data  = s4_r;

  // Stage 3: d.u on the four axes (A0, A1, B0, B1) and radius products
  always_comb begin
    dsum[0] = {up_data.dx_ac[40], up_data.dx_ac} + {up_data.dy_as[40], up_data.dy_as};
    dsum[1] = {up_data.dy_ac[40], up_data.dy_ac} - {up_data.dx_as[40], up_data.dx_as};
    dsum[2] = {up_data.dx_bc[40], up_data.dx_bc} + {up_data.dy_bs[40], up_data.dy_bs};
    dsum[3] = {up_data.dy_bc[40], up_data.dy_bc} - {up_data.dx_bs[40], up_data.dx_bs};
    for (int i = 0; i < 4; i++) begin
      s3_nxt.dproj[i] = dsum[i][41] ? 41'(~dsum[i] + 42'd1) : dsum[i][40:0];
    end
    s3_nxt.ahx_na = 55'(up_data.ahx) * 55'(up_data.na);
    s3_nxt.ahy_na = 55'(up_data.ahy) * 55'(up_data.na);
    s3_nxt.bhx_nb = 55'(up_data.bhx) * 55'(up_data.nb);
    s3_nxt.bhy_nb = 55'(up_data.bhy) * 55'(up_data.nb);
    s3_nxt.ahx_p  = 55'(up_data.ahx) * 55'(up_data.p_abs);
    s3_nxt.ahx_q  = 55'(up_data.ahx) * 55'(up_data.q_abs);
    s3_nxt.ahy_p  = 55'(up_data.ahy) * 55'(up_data.p_abs);
    s3_nxt.ahy_q  = 55'(up_data.ahy) * 55'(up_data.q_abs);
    s3_nxt.bhx_p  = 55'(up_data.bhx) * 55'(up_data.p_abs);
    s3_nxt.bhx_q  = 55'(up_data.bhx) * 55'(up_data.q_abs);
    s3_nxt.bhy_p  = 55'(up_data.bhy) * 55'(up_data.p_abs);
    s3_nxt.bhy_q  = 55'(up_data.bhy) * 55'(up_data.q_abs);
  end

  // Stage 4: radius sums; a box's own orthogonal axis adds nothing
  always_comb begin
    s4_nxt.dproj   = s3_r.dproj;
    s4_nxt.rsum[0] = 56'(s3_r.ahx_na) + 56'(s3_r.bhx_p) + 56'(s3_r.bhy_q);
    s4_nxt.rsum[1] = 56'(s3_r.ahy_na) + 56'(s3_r.bhx_q) + 56'(s3_r.bhy_p);
    s4_nxt.rsum[2] = 56'(s3_r.ahx_p) + 56'(s3_r.ahy_q) + 56'(s3_r.bhx_nb);
    s4_nxt.rsum[3] = 56'(s3_r.ahx_q) + 56'(s3_r.ahy_p) + 56'(s3_r.bhy_nb);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s3_en) begin
        s3_valid_r <= up_valid;
      end
      if (s4_en) begin
        s4_valid_r <= s3_valid_r;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_r <= s3_nxt;
    end
    if (s4_en) begin
      s4_r <= s4_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/obbpot_cmp.sv */
`default_nettype none

// Stage 5: compare scaled distance against radius sum on every axis and
// hold the verdict in the output register.
module obbpot_cmp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire obbpot_pkg::s4_t    up_data,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output logic                    overlap
);

  logic             valid_r;
  logic             overlap_r;
  logic             overlap_nxt;
  logic             en;
  logic [3:0]       sep;
  logic [3:0][55:0] dist_q36;

  assign en       = !valid_r || dn_ready;
  assign up_ready = en;
  assign dn_valid = valid_r;
  assign overlap  = overlap_r;

  // Scale distance by 2^14, flag axes that strictly separate
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dist_q36[i] = {1'b0, up_data.dproj[i], 14'b0};
      sep[i]      = dist_q36[i] > up_data.rsum[i];
    end
    overlap_nxt = ~|sep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      overlap_r <= overlap_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/obbpot_checker.sv */
`default_nettype none

module obbpot_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [obbpot_pkg::IN_TDATA_W-1:0] in_tdata,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [obbpot_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // A free output register lets the whole pipe take a new transaction
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled although output can drain");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

  // Pad bits above the verdict stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[obbpot_pkg::OUT_TDATA_W-1:1] == '0)
    else $error("result pad bits set");

endmodule

bind obb_pair_overlap_test obbpot_checker u_obbpot_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

/* bench/obb_pair_overlap_test_tb.sv */
`timescale 1ns / 1ps

module obb_pair_overlap_test_tb;

  localparam int ONE_Q14     = 16384;
  localparam int HOLD_LEN    = 150;
  localparam int HOLD1_START = 1500;
  localparam int HOLD2_START = 4000;
  localparam int DRAIN_WAIT  = 20;

  // Receiver back-pressure patterns
  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_ALT
  } rx_mode_t;

  // One oriented box as it travels on the input stream
  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic        [22:0] hx;
    logic        [22:0] hy;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
  } box_t;

  typedef struct packed {
    box_t a;
    box_t b;
  } pair_t;

  typedef struct {
    int idx;
    bit overlap;
  } verdict_t;

  logic clk;
  logic rst_n      = 1'b0;
  logic in_tvalid  = 1'b0;
  logic in_tready;
  logic [obbpot_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [obbpot_pkg::OUT_TDATA_W-1:0] out_tdata;

  pair_t    pending[$];
  verdict_t verdict_q[$];
  pair_t    cur_pair;
  verdict_t want;
  int       n_sent    = 0;
  int       n_items   = 0;
  int       n_errors  = 0;
  int       burst_left = 0;
  int       gap_left   = 0;
  int unsigned rx_cycle = 0;
  rx_mode_t rx_mode = RX_FREE;

  obb_pair_overlap_test u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Magnitude of a signed product sum
  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Projection radius (Q.36) of a box with axes (c,s),(-s,c) onto axis (ux,uy)
  function automatic longint proj_radius(logic [22:0] hx, logic [22:0] hy,
                                         longint c, longint s,
                                         longint ux, longint uy);
    longint hxl;
    longint hyl;
    hxl = longint'(hx);
    hyl = longint'(hy);
    return hxl * mag(ux * c + uy * s) + hyl * mag(uy * c - ux * s);
  endfunction

  // Separating-axis verdict over the four box axes, exact in 64 bits
  function automatic bit obb_overlap(pair_t p);
    longint dx;
    longint dy;
    longint ux[4];
    longint uy[4];
    longint dproj;
    longint rsum;
    bit     hit;
    dx = longint'(p.b.cx) - longint'(p.a.cx);
    dy = longint'(p.b.cy) - longint'(p.a.cy);
    ux[0] = p.a.cs;  uy[0] = p.a.sn;
    ux[1] = -longint'(p.a.sn); uy[1] = p.a.cs;
    ux[2] = p.b.cs;  uy[2] = p.b.sn;
    ux[3] = -longint'(p.b.sn); uy[3] = p.b.cs;
    hit = 1'b1;
    for (int i = 0; i < 4; i++) begin
      dproj = mag(dx * ux[i] + dy * uy[i]) * ONE_Q14;
      rsum = proj_radius(p.a.hx, p.a.hy, p.a.cs, p.a.sn, ux[i], uy[i])
           + proj_radius(p.b.hx, p.b.hy, p.b.cs, p.b.sn, ux[i], uy[i]);
      if (dproj > rsum) hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic box_t mk_box(int cx, int cy, int hx, int hy, int cs, int sn);
    box_t bx;
    bx.cx = 24'(cx);
    bx.cy = 24'(cy);
    bx.hx = 23'(hx);
    bx.hy = 23'(hy);
    bx.cs = 16'(cs);
    bx.sn = 16'(sn);
    return bx;
  endfunction

  // Box with a random rotation, mostly unit axis, sizes mostly small
  function automatic box_t rand_box();
    box_t        bx;
    real         ang;
    real         gain;
    int unsigned sh;
    int unsigned pick;
    ang  = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
    pick = $urandom_range(0, 19);
    gain = (pick == 0) ? real'($urandom_range(0, 32767)) : 16384.0;
    bx.cs = 16'($rtoi($cos(ang) * gain));
    bx.sn = 16'($rtoi($sin(ang) * gain));
    if (pick == 1) begin
      bx.cs = '0;
      bx.sn = '0;
    end
    sh = ($urandom_range(0, 9) == 0) ? 23 : $urandom_range(2, 16);
    bx.hx = 23'($urandom_range(0, (1 << sh) - 1));
    sh = ($urandom_range(0, 9) == 0) ? 23 : $urandom_range(2, 16);
    bx.hy = 23'($urandom_range(0, (1 << sh) - 1));
    bx.cx = 24'($urandom);
    bx.cy = 24'($urandom);
    return bx;
  endfunction

  // Mostly box pairs placed near contact, some raw bit patterns
  function automatic pair_t rand_pair();
    pair_t        p;
    logic [255:0] raw;
    int           reach;
    int           span;
    if ($urandom_range(0, 9) == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
      p = raw[251:0];
    end else begin
      p.a   = rand_box();
      p.b   = rand_box();
      reach = int'(p.a.hx) + int'(p.a.hy) + int'(p.b.hx) + int'(p.b.hy);
      span  = 3 * reach + 2;
      p.b.cx = p.a.cx + 24'(int'($urandom_range(0, span)) - span / 2);
      p.b.cy = p.a.cy + 24'(int'($urandom_range(0, span)) - span / 2);
    end
    return p;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Sender: bursts of random length with random gaps, hold data until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        verdict_q.push_back('{n_sent, obb_overlap(cur_pair)});
        n_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          cur_pair = pending.pop_front();
          in_tdata <= {4'b0,
                       cur_pair.b.sn, cur_pair.b.cs, cur_pair.b.hy, cur_pair.b.hx,
                       cur_pair.b.cy, cur_pair.b.cx,
                       cur_pair.a.sn, cur_pair.a.cs, cur_pair.a.hy, cur_pair.a.hx,
                       cur_pair.a.cy, cur_pair.a.cx};
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each verdict, then pick the next ready level
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_cycle   = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected transaction, overlap expected none got %0d",
                   $time, out_tdata[0]);
          n_errors++;
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[0] !== want.overlap) begin
            $display("%0t: pair %0d overlap expected %0d got %0d",
                     $time, want.idx, want.overlap, out_tdata[0]);
            n_errors++;
          end
        end
      end
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      // long hold-offs so the pipeline fills and stalls its input
      if ((rx_cycle >= HOLD1_START && rx_cycle < HOLD1_START + HOLD_LEN) ||
          (rx_cycle >= HOLD2_START && rx_cycle < HOLD2_START + HOLD_LEN)) begin
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:   out_tready <= rx_cycle[0];
        endcase
      end
    end
  end

  // Stimulus and end of run
  initial begin
    // all zero: no axis can separate
    pending.push_back('{mk_box(0, 0, 0, 0, 0, 0), mk_box(0, 0, 0, 0, 0, 0)});
    // axis-aligned, exactly touching, then one step apart
    pending.push_back('{mk_box(0, 0, 256, 256, ONE_Q14, 0),
                        mk_box(512, 0, 256, 256, ONE_Q14, 0)});
    pending.push_back('{mk_box(0, 0, 256, 256, ONE_Q14, 0),
                        mk_box(513, 0, 256, 256, ONE_Q14, 0)});
    // box B turned a quarter, touching and apart along y
    pending.push_back('{mk_box(0, 0, 256, 100, ONE_Q14, 0),
                        mk_box(0, 400, 300, 50, 0, ONE_Q14)});
    pending.push_back('{mk_box(0, 0, 256, 100, ONE_Q14, 0),
                        mk_box(0, 401, 300, 50, 0, ONE_Q14)});
    // extreme centers, empty and full boxes
    pending.push_back('{mk_box(-8388608, -8388608, 0, 0, ONE_Q14, 0),
                        mk_box(8388607, 8388607, 0, 0, ONE_Q14, 0)});
    pending.push_back('{mk_box(-8388608, -8388608, 8388607, 8388607, ONE_Q14, 0),
                        mk_box(8388607, 8388607, 8388607, 8388607, ONE_Q14, 0)});
    // most negative axis components
    pending.push_back('{mk_box(1000, -2000, 5000, 300, -32768, -32768),
                        mk_box(-7000, 4000, 70, 9000, -32768, -32768)});
    // zero axes on both boxes never separate
    pending.push_back('{mk_box(-8388608, 0, 0, 0, 0, 0),
                        mk_box(8388607, 0, 0, 0, 0, 0)});
    // zero axis on box A only, box B separates
    pending.push_back('{mk_box(0, 0, 500, 500, 0, 0),
                        mk_box(100000, 0, 10, 10, ONE_Q14, 0)});
    // non-unit axis used as given
    pending.push_back('{mk_box(0, 0, 256, 256, ONE_Q14, ONE_Q14),
                        mk_box(700, 0, 256, 256, ONE_Q14, 0)});
    // components outside the unit range
    pending.push_back('{mk_box(-300, 200, 4000, 100, 32767, -32768),
                        mk_box(300, -200, 20, 6000, -32768, 32767)});
    // boxes at 45 degrees
    pending.push_back('{mk_box(0, 0, 1000, 500, 11585, 11585),
                        mk_box(1500, 1500, 1000, 500, 11585, -11585)});
    pending.push_back('{mk_box(0, 0, 1000, 500, 11585, 11585),
                        mk_box(2200, -300, 200, 500, ONE_Q14, 0)});
    // all ones
    pending.push_back('{mk_box(-1, -1, 8388607, 8388607, -1, -1),
                        mk_box(-1, -1, 8388607, 8388607, -1, -1)});
    // identical rotated boxes
    pending.push_back('{mk_box(12345, -6789, 300, 40, 9000, -13693),
                        mk_box(12345, -6789, 300, 40, 9000, -13693)});
    // opposite corners of the range, opposite rotations
    pending.push_back('{mk_box(8388607, -8388608, 8388607, 0, ONE_Q14, -ONE_Q14),
                        mk_box(-8388608, 8388607, 0, 8388607, -ONE_Q14, ONE_Q14)});
    repeat (2000) pending.push_back(rand_pair());
    n_items = pending.size();

    while (!rst_n) @(posedge clk);
    while (n_sent < n_items) @(posedge clk);
    while (verdict_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
